FILE: rtl/countdown_timer_controller_core_assert.svh
// Assertion helpers shared by the timer controller RTL.
`ifndef COUNTDOWN_TIMER_CONTROLLER_CORE_ASSERT_SVH
`define COUNTDOWN_TIMER_CONTROLLER_CORE_ASSERT_SVH

// Immediate-consequence property, checked on every rising edge outside reset.
`define CTC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that compares against the value of the previous cycle.
`define CTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ctc_pkg.sv
package ctc_pkg;

  localparam int unsigned IN_W   = 8;
  localparam int unsigned OUT_W  = 56;

  localparam logic [2:0] EV_TICK  = 3'd0;
  localparam logic [2:0] EV_INC   = 3'd1;
  localparam logic [2:0] EV_DEC   = 3'd2;
  localparam logic [2:0] EV_START = 3'd3;
  localparam logic [2:0] EV_ABORT = 3'd4;

  localparam logic [2:0] CODE_IDLE  = 3'd0;
  localparam logic [2:0] CODE_SET   = 3'd1;
  localparam logic [2:0] CODE_STAT  = 3'd2;
  localparam logic [2:0] CODE_COUNT = 3'd3;
  localparam logic [2:0] CODE_PAUSE = 3'd4;

  localparam logic [3:0]  SUB_FULL     = 4'd10;
  localparam logic [3:0]  SUB_BEEP     = 4'd5;
  localparam logic [15:0] SECS_PER_MIN = 16'd60;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SET   = 5'b00010,
    ST_STAT  = 5'b00100,
    ST_COUNT = 5'b01000,
    ST_PAUSE = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    RES_IGNORED = 2'd0,
    RES_HANDLED = 2'd1,
    RES_TRANS   = 2'd2
  } status_e;

  // Numeric code of a state as it appears on the result item.
  function automatic logic [2:0] state_code(state_e st);
    logic [2:0] code;
    unique case (st)
      ST_IDLE:  code = CODE_IDLE;
      ST_SET:   code = CODE_SET;
      ST_STAT:  code = CODE_STAT;
      ST_COUNT: code = CODE_COUNT;
      ST_PAUSE: code = CODE_PAUSE;
      default:  code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/countdown_timer_controller_core.sv
// Countdown timer controller with set, statistics, countdown and pause states.
// Input channel (s_axis): one item per timer event, carrying the event kind
// and the tenth-of-second count of a tick. Output channel (m_axis): exactly
// one result item per event with the new state code, remaining seconds,
// accumulated productive seconds, a beep pulse and a status code.
// Throughput is one item per clock cycle while the receiver takes results:
// the whole state update for an event is a single pass of small adders and
// compares between the input register and the result register. Each item
// passes through the input register and then the result register. The state
// registers advance when an item moves from the input register into the
// result register.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; after that s_axis_tready drops
// until the result is taken. No item is lost or repeated.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// timer to idle with all counts at zero.
module countdown_timer_controller_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [2:0] mode, [6:3] subsecond, [7] zero
  input  logic [ctc_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [2:0] state_code, [18:3] remaining_seconds, [50:19] productive_seconds,
  // [51] beep, [53:52] status, [55:54] zero
  output logic [ctc_pkg::OUT_W-1:0] m_axis_tdata
);

  import ctc_pkg::*;

  `include "countdown_timer_controller_core_assert.svh"

  // Input register.
  logic       in_vld_q;
  logic [2:0] in_mode_q;
  logic [3:0] in_sub_q;

  // Timer state.
  state_e      st_q, st_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] run_q, run_d;
  logic [31:0] prod_q, prod_d;

  // Result register.
  logic        out_vld_q;
  logic [2:0]  out_code_q;
  logic [15:0] out_rem_q;
  logic [31:0] out_prod_q;
  logic        out_beep_q;
  status_e     out_status_q;

  logic        beep_d;
  status_e     status_d;
  logic        adv;
  logic [16:0] rem_add;
  logic [15:0] rem_sat;
  logic [32:0] prod_sum;

  // An item moves forward when the result register is empty or being drained.
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= s_axis_tdata[2:0];
      in_sub_q  <= s_axis_tdata[6:3];
    end
  end

  // Adding a minute saturates at the top of the 16-bit counter.
  assign rem_add = {1'b0, rem_q} + {1'b0, SECS_PER_MIN};
  assign rem_sat = rem_add[16] ? 16'hFFFF : rem_add[15:0];

  always_comb begin
    st_d     = st_q;
    rem_d    = rem_q;
    run_d    = run_q;
    prod_d   = prod_q;
    beep_d   = 1'b0;
    status_d = RES_IGNORED;
    prod_sum = '0;

    unique case (st_q)
      ST_IDLE: begin
        priority case (in_mode_q)
          EV_TICK: begin
            if (in_sub_q == SUB_BEEP) begin
              beep_d   = 1'b1;
              status_d = RES_HANDLED;
            end
          end
          EV_START: begin
            st_d     = ST_STAT;
            status_d = RES_TRANS;
          end
          EV_INC: begin
            rem_d    = rem_sat;
            st_d     = ST_SET;
            status_d = RES_TRANS;
          end
          default: ;
        endcase
      end
      ST_SET: begin
        priority case (in_mode_q)
          EV_START: begin
            if (rem_q >= SECS_PER_MIN) begin
              st_d     = ST_COUNT;
              status_d = RES_TRANS;
            end
          end
          EV_ABORT: begin
            st_d     = ST_IDLE;
            status_d = RES_TRANS;
          end
          EV_INC: begin
            rem_d    = rem_sat;
            status_d = RES_HANDLED;
          end
          EV_DEC: begin
            if (rem_q >= SECS_PER_MIN) begin
              rem_d    = rem_q - SECS_PER_MIN;
              status_d = RES_HANDLED;
            end
          end
          default: ;
        endcase
      end
      ST_STAT: begin
        if (in_mode_q == EV_TICK && in_sub_q == SUB_FULL) begin
          st_d     = ST_IDLE;
          status_d = RES_TRANS;
        end
      end
      ST_COUNT: begin
        priority case (in_mode_q)
          EV_TICK: begin
            if (in_sub_q == SUB_FULL) begin
              if (rem_q != 16'd0) begin
                rem_d = rem_q - 16'd1;
                run_d = (run_q == 16'hFFFF) ? run_q : run_q + 16'd1;
              end
              if (rem_d == 16'd0) begin
                st_d     = ST_IDLE;
                status_d = RES_TRANS;
              end else begin
                status_d = RES_HANDLED;
              end
            end
          end
          EV_START: begin
            st_d     = ST_PAUSE;
            status_d = RES_TRANS;
          end
          EV_ABORT: begin
            st_d     = ST_IDLE;
            status_d = RES_TRANS;
          end
          default: ;
        endcase
      end
      ST_PAUSE: begin
        // Minute changes while paused report a transition but stay paused.
        priority case (in_mode_q)
          EV_START: begin
            st_d     = ST_COUNT;
            status_d = RES_TRANS;
          end
          EV_ABORT: begin
            st_d     = ST_IDLE;
            status_d = RES_TRANS;
          end
          EV_INC: begin
            rem_d    = rem_sat;
            status_d = RES_TRANS;
          end
          EV_DEC: begin
            if (rem_q >= SECS_PER_MIN) begin
              rem_d    = rem_q - SECS_PER_MIN;
              status_d = RES_TRANS;
            end
          end
          default: ;
        endcase
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // Leaving the countdown banks the run's seconds, including a final tick.
    if (st_q == ST_COUNT && st_d != ST_COUNT) begin
      prod_sum = {1'b0, prod_q} + {17'd0, run_d};
      prod_d   = prod_sum[32] ? 32'hFFFF_FFFF : prod_sum[31:0];
      run_d    = 16'd0;
    end
    // Idle always carries empty remaining and run counts.
    if (st_d == ST_IDLE) begin
      rem_d = 16'd0;
      run_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      rem_q  <= 16'd0;
      run_q  <= 16'd0;
      prod_q <= 32'd0;
    end else if (adv) begin
      st_q   <= st_d;
      rem_q  <= rem_d;
      run_q  <= run_d;
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_code_q   <= state_code(st_d);
      out_rem_q    <= rem_d;
      out_prod_q   <= prod_d;
      out_beep_q   <= beep_d;
      out_status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_status_q, out_beep_q, out_prod_q, out_rem_q, out_code_q};

  // The idle state never holds remaining or run seconds.
  `CTC_ASSERT(a_idle_clear, clk_i, rst_ni,
              (st_q != ST_IDLE) || (rem_q == 16'd0 && run_q == 16'd0),
              "idle state with nonzero counts")

  // Run seconds are only nonzero in the countdown or pause states.
  `CTC_ASSERT(a_run_in_count, clk_i, rst_ni,
              (run_q == 16'd0) || (st_q == ST_COUNT) || (st_q == ST_PAUSE),
              "run seconds outside countdown")

  // The productive total never goes down.
  `CTC_ASSERT_NEXT(a_prod_mono, clk_i, rst_ni, 1'b1, prod_q >= $past(prod_q),
                   "productive total decreased")

  // A beep is only reported as a handled event in idle.
  `CTC_ASSERT(a_beep_idle, clk_i, rst_ni,
              !(out_vld_q && out_beep_q) ||
              (out_code_q == CODE_IDLE && out_status_q == RES_HANDLED),
              "beep outside idle")

endmodule

FILE: tb/tb_countdown_timer_controller_core.sv
module tb_countdown_timer_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ctc_pkg::*;

  // Fields of one result item as the block reports them.
  typedef struct packed {
    logic [2:0]  code;
    logic [15:0] secs;
    logic [31:0] productive;
    logic        beep;
    status_e     status;
  } timer_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [2:0] mode, [6:3] subsecond, [7] zero
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [2:0] state_code, [18:3] remaining_seconds, [50:19] productive_seconds,
  // [51] beep, [53:52] status, [55:54] zero
  logic [OUT_W-1:0]    m_axis_tdata;

  // Predicted timer state, advanced once per accepted event item.
  logic [2:0]          timer_state = CODE_IDLE;
  logic [15:0]         secs_left = '0;
  logic [15:0]         run_secs = '0;
  logic [31:0]         productive_secs = '0;

  timer_result_t       pending_results[$];
  int unsigned         mismatch_count = 0;
  int unsigned         burst_left = 0;
  bit                  hold_req = 1'b0;

  countdown_timer_controller_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("countdown_timer_controller_core test failed");
    $finish;
  end

  // Adds one minute to the countdown, saturating at the counter limit.
  function automatic void add_minute();
    logic [16:0] sum;
    sum = {1'b0, secs_left} + {1'b0, SECS_PER_MIN};
    secs_left = sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // Moves to a new state; leaving the countdown banks the run's seconds,
  // and entering idle clears the counts.
  function automatic void enter_state(input logic [2:0] next);
    logic [32:0] sum;
    if (timer_state == CODE_COUNT && next != CODE_COUNT) begin
      sum = {1'b0, productive_secs} + {17'd0, run_secs};
      productive_secs = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      run_secs = '0;
    end
    if (next == CODE_IDLE) begin
      secs_left = '0;
      run_secs = '0;
    end
    timer_state = next;
  endfunction

  // Applies one event to the predicted timer and returns the result it causes.
  function automatic timer_result_t step_timer(input logic [2:0] ev, input logic [3:0] sub);
    timer_result_t r;
    r.beep = 1'b0;
    r.status = RES_IGNORED;
    case (timer_state)
      CODE_IDLE: begin
        if (ev == EV_TICK) begin
          if (sub == SUB_BEEP) begin
            r.beep = 1'b1;
            r.status = RES_HANDLED;
          end
        end else if (ev == EV_START) begin
          enter_state(CODE_STAT);
          r.status = RES_TRANS;
        end else if (ev == EV_INC) begin
          add_minute();
          enter_state(CODE_SET);
          r.status = RES_TRANS;
        end
      end
      CODE_SET: begin
        if (ev == EV_START) begin
          if (secs_left >= SECS_PER_MIN) begin
            enter_state(CODE_COUNT);
            r.status = RES_TRANS;
          end
        end else if (ev == EV_ABORT) begin
          enter_state(CODE_IDLE);
          r.status = RES_TRANS;
        end else if (ev == EV_INC) begin
          add_minute();
          r.status = RES_HANDLED;
        end else if (ev == EV_DEC) begin
          if (secs_left >= SECS_PER_MIN) begin
            secs_left = secs_left - SECS_PER_MIN;
            r.status = RES_HANDLED;
          end
        end
      end
      CODE_STAT: begin
        if (ev == EV_TICK && sub == SUB_FULL) begin
          enter_state(CODE_IDLE);
          r.status = RES_TRANS;
        end
      end
      CODE_COUNT: begin
        if (ev == EV_TICK) begin
          if (sub == SUB_FULL) begin
            // A completing tick with nothing left counts nothing and ends the run.
            if (secs_left != 0) begin
              secs_left = secs_left - 16'd1;
              if (run_secs != 16'hFFFF) run_secs = run_secs + 16'd1;
            end
            if (secs_left == 0) begin
              enter_state(CODE_IDLE);
              r.status = RES_TRANS;
            end else begin
              r.status = RES_HANDLED;
            end
          end
        end else if (ev == EV_START) begin
          enter_state(CODE_PAUSE);
          r.status = RES_TRANS;
        end else if (ev == EV_ABORT) begin
          enter_state(CODE_IDLE);
          r.status = RES_TRANS;
        end
      end
      CODE_PAUSE: begin
        // Minute changes while paused report a transition without leaving pause.
        if (ev == EV_START) begin
          enter_state(CODE_COUNT);
          r.status = RES_TRANS;
        end else if (ev == EV_ABORT) begin
          enter_state(CODE_IDLE);
          r.status = RES_TRANS;
        end else if (ev == EV_INC) begin
          add_minute();
          r.status = RES_TRANS;
        end else if (ev == EV_DEC) begin
          if (secs_left >= SECS_PER_MIN) begin
            secs_left = secs_left - SECS_PER_MIN;
            r.status = RES_TRANS;
          end
        end
      end
      default: timer_state = CODE_IDLE;
    endcase
    r.code = timer_state;
    r.secs = secs_left;
    r.productive = productive_secs;
    return r;
  endfunction

  // Offers one event item, in bursts with random gaps, and records the
  // predicted result once the block accepts it.
  task automatic send_event(input logic [2:0] ev, input logic [3:0] sub);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, sub, ev};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(step_timer(ev, sub));
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Result side: checks each accepted result item against the oldest
  // prediction, then picks the next ready level. The stall style is redrawn
  // at random, and a requested hold-off keeps ready low for a long stretch
  // so that both registers of the block fill up.
  int unsigned stall_style = 0;
  int unsigned style_left = 0;
  int unsigned hold_left = 0;
  int unsigned phase_cnt = 0;

  always @(posedge clk_i) begin
    timer_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result item, actual %h", $time, m_axis_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        report_field("state_code", 32'(exp_r.code), 32'(m_axis_tdata[2:0]));
        report_field("remaining_seconds", 32'(exp_r.secs), 32'(m_axis_tdata[18:3]));
        report_field("productive_seconds", exp_r.productive, m_axis_tdata[50:19]);
        report_field("beep", 32'(exp_r.beep), 32'(m_axis_tdata[51]));
        report_field("status", 32'(exp_r.status), 32'(m_axis_tdata[53:52]));
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left = $urandom_range(64, 256);
    end else begin
      style_left--;
    end
    phase_cnt++;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_style)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (phase_cnt % 3) != 0;
        default: m_axis_tready <= $urandom_range(0, 9) != 0;
      endcase
    end
  end

  // Each state visited with a mix of event kinds, the beep tick, unknown event codes,
  // extreme subsecond values and a zero-second countdown tick.
  task automatic test_directed_events();
    send_event(EV_TICK, SUB_BEEP);
    send_event(EV_TICK, 4'd15);
    send_event(EV_DEC, 4'd0);
    send_event(EV_ABORT, 4'd0);
    send_event(3'd5, 4'd10);
    send_event(3'd7, SUB_BEEP);
    send_event(EV_START, 4'd0);
    send_event(EV_INC, 4'd0);
    send_event(EV_TICK, SUB_FULL);
    send_event(EV_INC, 4'd3);
    send_event(EV_DEC, 4'd0);
    send_event(EV_DEC, 4'd0);
    send_event(EV_START, 4'd0);
    send_event(EV_INC, 4'd0);
    send_event(EV_START, 4'd0);
    send_event(EV_TICK, SUB_FULL);
    send_event(EV_TICK, 4'd9);
    send_event(EV_START, 4'd0);
    send_event(EV_INC, 4'd0);
    send_event(EV_DEC, 4'd0);
    send_event(EV_DEC, 4'd0);
    send_event(EV_ABORT, 4'd0);
    // Pause lets the count drop to zero before the countdown resumes.
    send_event(EV_INC, 4'd0);
    send_event(EV_START, 4'd0);
    send_event(EV_START, 4'd0);
    send_event(EV_DEC, 4'd0);
    send_event(EV_START, 4'd0);
    send_event(EV_TICK, SUB_FULL);
  endtask

  // One full minute counted down to zero, with non-completing ticks mixed in.
  task automatic test_full_countdown();
    send_event(EV_INC, 4'd0);
    send_event(EV_START, 4'd0);
    for (int i = 0; i < 60; i++) begin
      if (i % 7 == 3) send_event(EV_TICK, 4'(i % 10));
      send_event(EV_TICK, SUB_FULL);
    end
  endtask

  // Minutes added until the remaining count saturates.
  task automatic test_minute_saturation();
    for (int i = 0; i < 1095; i++) send_event(EV_INC, 4'(i));
    send_event(EV_DEC, 4'd0);
    send_event(EV_INC, 4'd0);
    send_event(EV_START, 4'd0);
    send_event(EV_TICK, SUB_FULL);
    send_event(EV_ABORT, 4'd0);
  endtask

  // The result side holds off while events keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    burst_left = 40;
    send_event(EV_INC, 4'd0);
    send_event(EV_INC, 4'd0);
    send_event(EV_START, 4'd0);
    for (int i = 0; i < 20; i++) send_event(EV_TICK, SUB_FULL);
    send_event(EV_ABORT, 4'd0);
  endtask

  // Mostly well-formed timer sessions chosen from the predicted state,
  // with a share of arbitrary event codes and subsecond values.
  task automatic test_random_events(input int unsigned count);
    int unsigned p;
    logic [2:0] ev;
    logic [3:0] sub;
    for (int unsigned i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      ev = 3'($urandom_range(0, 7));
      sub = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) >= 12) begin
        case (timer_state)
          CODE_IDLE:  ev = (p < 65) ? EV_INC : (p < 80) ? EV_START : EV_TICK;
          CODE_SET:   ev = (p < 30) ? EV_INC : (p < 45) ? EV_DEC :
                           (p < 95) ? EV_START : EV_ABORT;
          CODE_STAT: begin
            ev = EV_TICK;
            if (p < 40) sub = SUB_FULL;
          end
          CODE_COUNT: begin
            if (p < 88) begin
              ev = EV_TICK;
              sub = SUB_FULL;
            end else begin
              ev = (p < 93) ? EV_TICK : (p < 97) ? EV_START :
                   (p < 98) ? EV_INC : (p < 99) ? EV_DEC : EV_ABORT;
            end
          end
          CODE_PAUSE: ev = (p < 50) ? EV_START : (p < 70) ? EV_INC :
                           (p < 90) ? EV_DEC : EV_ABORT;
          default: ;
        endcase
      end
      send_event(ev, sub);
    end
  endtask

  initial begin
    int unsigned wait_cycles;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_events();
    test_full_countdown();
    test_minute_saturation();
    test_backpressure();
    test_random_events(480);
    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected result items never arrived", $time,
               pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("countdown_timer_controller_core test passed");
    end else begin
      $display("countdown_timer_controller_core test failed");
    end
    $finish;
  end

endmodule
